>>> hw/rtl/kssd_pkg.sv
// Shared types and constants for the K-th smallest squared distance block.
`timescale 1ns / 1ps
package kssd_pkg;

  localparam int MAX_KEEP = 64;
  localparam int CNT_W    = 7;
  localparam int COORD_W  = 32;
  localparam int DIST_W   = 64;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  // Command broadcast to every cell of the sorted chain.
  typedef struct packed {
    logic [DIST_W-1:0] sq_dist;
    logic              add_en;
    logic              rep_en;
  } cell_cmd_t;

  // Clamp the keep count into 1..MAX_KEEP.
  function automatic logic [CNT_W-1:0] limit_k(input logic [CNT_W-1:0] k);
    logic [CNT_W-1:0] r;
    r = k;
    if (k == '0) r = CNT_W'(1);
    else if (k > CNT_W'(MAX_KEEP)) r = CNT_W'(MAX_KEEP);
    return r;
  endfunction

endpackage

>>> hw/rtl/kth_smallest_squared_distance.sv
// Top level: K-th smallest squared distance over a stream of points.
`timescale 1ns / 1ps
// Keeps the K smallest squared distances x*x+y*y (exact, 64 bits) of the points
// inserted so far in a chain of MAX_KEEP cells sorted largest first, so a query
// reads the K-th smallest from cell zero. op is carried in in_tuser (0 insert,
// 1 query); each query beat yields one result beat, an insert yields none. Items
// flow through a four-stage pipeline (magnitude, square, sum, chain update) and
// one item is taken every cycle unless the result register is stalled; a query's
// result is registered after its sum stage. keep_count of 0 acts as 1 and
// values above MAX_KEEP act as MAX_KEEP; write it only while the block is idle.
module kth_smallest_squared_distance
  import kssd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CNT_W-1:0]    cfg_wr_data,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [2*COORD_W-1:0] in_tdata,   // x_coord [31:0], y_coord [63:32]
  input  logic                in_tuser,   // op
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [DIST_W-1:0]   out_tdata,  // kth_distance
  output logic                out_tuser   // empty_res
);

  logic [CNT_W-1:0]  keep_r;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [CNT_W-1:0]  k_lim;
  logic              advance;
  logic              d_valid;
  op_t               d_op;
  logic [DIST_W-1:0] d_dist;
  cell_cmd_t         cmd;
  logic              do_insert;

  logic              out_tvalid_r, out_tvalid_nxt;
  logic [DIST_W-1:0] out_tdata_r;
  logic              out_tuser_r;

  logic [DIST_W-1:0] cell_val [MAX_KEEP];
  logic              cell_ge  [MAX_KEEP];
  logic              cell_gt  [MAX_KEEP];

  assign advance   = !out_tvalid_r || out_tready;
  assign in_tready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) keep_r <= CNT_W'(1);
    else if (cfg_wr_en) keep_r <= cfg_wr_data;
  end

  assign k_lim = limit_k(keep_r);

  kssd_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .in_valid (in_tvalid),
    .in_op    (op_t'(in_tuser)),
    .in_x     (in_tdata[COORD_W-1:0]),
    .in_y     (in_tdata[2*COORD_W-1:COORD_W]),
    .out_valid(d_valid),
    .out_op   (d_op),
    .out_dist (d_dist)
  );

  assign do_insert   = advance && d_valid && (d_op == OP_INSERT);
  assign cmd.sq_dist = d_dist;
  assign cmd.add_en  = do_insert && (held_r < k_lim);
  assign cmd.rep_en  = do_insert && !(held_r < k_lim) && cell_gt[0];

  assign held_nxt = cmd.add_en ? held_r + CNT_W'(1) : held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) held_r <= '0;
    else held_r <= held_nxt;
  end

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    logic [DIST_W-1:0] lv, rv;
    logic              lge, rgt;
    if (i == 0) begin : g_head
      assign lv  = '0;
      assign lge = 1'b1;
    end else begin : g_mid
      assign lv  = cell_val[i-1];
      assign lge = cell_ge[i-1];
    end
    if (i == MAX_KEEP-1) begin : g_tail
      assign rv  = '0;
      assign rgt = 1'b0;
    end else begin : g_body
      assign rv  = cell_val[i+1];
      assign rgt = cell_gt[i+1];
    end
    kssd_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .held     (held_r > CNT_W'(i)),
      .left_val (lv),
      .left_ge  (lge),
      .right_val(rv),
      .right_gt (rgt),
      .val      (cell_val[i]),
      .ge       (cell_ge[i]),
      .gt       (cell_gt[i])
    );
  end

  assign out_tvalid_nxt = advance ? (d_valid && (d_op == OP_QUERY)) : out_tvalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid_r <= 1'b0;
    else out_tvalid_r <= out_tvalid_nxt;
  end

  always_ff @(posedge clk) begin
    if (advance && d_valid && (d_op == OP_QUERY)) begin
      out_tuser_r <= (held_r == '0);
      out_tdata_r <= (held_r == '0) ? '0 : cell_val[0];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(MAX_KEEP))
    else $error("held count above capacity");

  a_held_grows: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> held_r >= $past(held_r))
    else $error("held count decreased");

  a_head_max: assert property (@(posedge clk) disable iff (!rst_n)
    held_r >= CNT_W'(2) |-> cell_val[0] >= cell_val[1])
    else $error("chain head is not the largest held distance");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("empty result carries a nonzero distance");

endmodule

>>> hw/rtl/kssd_dist.sv
// Three-stage pipeline that turns a point into its exact squared distance.
`timescale 1ns / 1ps
module kssd_dist
  import kssd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      advance,
  input  logic                      in_valid,
  input  op_t                       in_op,
  input  logic signed [COORD_W-1:0] in_x,
  input  logic signed [COORD_W-1:0] in_y,
  output logic                      out_valid,
  output op_t                       out_op,
  output logic [DIST_W-1:0]         out_dist
);

  logic                 s1_valid_r, s2_valid_r, s3_valid_r;
  op_t                  s1_op_r, s2_op_r, s3_op_r;
  logic [COORD_W-1:0]   ax_r, ay_r;
  logic [COORD_W-1:0]   ax_nxt, ay_nxt;
  logic [DIST_W-1:0]    sqx_r, sqy_r;
  logic [DIST_W-1:0]    dist_r;

  // Magnitude of a two's complement coordinate; the most negative value maps to 2^31.
  assign ax_nxt = in_x[COORD_W-1] ? (~in_x + COORD_W'(1)) : in_x;
  assign ay_nxt = in_y[COORD_W-1] ? (~in_y + COORD_W'(1)) : in_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op_r <= in_op;
      ax_r    <= ax_nxt;
      ay_r    <= ay_nxt;
      s2_op_r <= s1_op_r;
      sqx_r   <= DIST_W'(ax_r) * DIST_W'(ax_r);
      sqy_r   <= DIST_W'(ay_r) * DIST_W'(ay_r);
      s3_op_r <= s2_op_r;
      dist_r  <= sqx_r + sqy_r;
    end
  end

  assign out_valid = s3_valid_r;
  assign out_op    = s3_op_r;
  assign out_dist  = dist_r;

endmodule

>>> hw/rtl/kssd_cell.sv
// One cell of the sorted chain: holds one distance, largest values toward cell zero.
`timescale 1ns / 1ps
module kssd_cell
  import kssd_pkg::*;
(
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic              held,
  input  logic [DIST_W-1:0] left_val,
  input  logic              left_ge,
  input  logic [DIST_W-1:0] right_val,
  input  logic              right_gt,
  output logic [DIST_W-1:0] val,
  output logic              ge,
  output logic              gt
);

  logic [DIST_W-1:0] value_r, value_nxt;

  assign ge = held && (value_r >= cmd.sq_dist);
  assign gt = held && (value_r >  cmd.sq_dist);

  always_comb begin
    value_nxt = value_r;
    if (cmd.add_en) begin
      // Open a slot: keep if not smaller, take the new distance at the boundary, else shift right.
      if (!ge) value_nxt = left_ge ? cmd.sq_dist : left_val;
    end else if (cmd.rep_en) begin
      // Drop the head: shift larger values left, drop the new distance in behind them.
      if (right_gt)  value_nxt = right_val;
      else if (gt)   value_nxt = cmd.sq_dist;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign val = value_r;

endmodule

>>> tb/kth_smallest_squared_distance_tb.sv
// Testbench for the K-th smallest squared distance block.
`timescale 1ns / 1ps
module kth_smallest_squared_distance_tb;
  import kssd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 10;

  typedef struct {
    logic [DIST_W-1:0] kth_dist;
    logic              empty;
  } kth_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]       cfg_wr_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [2*COORD_W-1:0]   in_tdata = '0;   // x_coord [31:0], y_coord [63:32]
  logic                   in_tuser = 1'b0; // op
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [DIST_W-1:0]      out_tdata;       // kth_distance
  logic                   out_tuser;       // empty_res

  kth_smallest_squared_distance dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  // Shadow state of the distance store.
  logic [DIST_W-1:0] kept_dist [MAX_KEEP];
  int                held_num = 0;
  logic [CNT_W-1:0]  keep_reg = CNT_W'(1);
  kth_result_t       pending_kth[$];
  kth_result_t       front_kth;

  int mismatch_count = 0;
  int burst_left = 1;
  int gap_max = 4;
  int hold_reqs = 0;
  int hold_served = 0;
  int hold_left = 0;
  int rx_count = 0;
  int rx_mode = 0;
  int stall_cycles = 0;

  function automatic logic [DIST_W-1:0] square_distance(logic [31:0] x, logic [31:0] y);
    logic [31:0] ax;
    logic [31:0] ay;
    ax = x[31] ? -x : x;
    ay = y[31] ? -y : y;
    return {32'd0, ax} * {32'd0, ax} + {32'd0, ay} * {32'd0, ay};
  endfunction

  function automatic int largest_slot();
    int best;
    best = 0;
    for (int i = 1; i < held_num; i++)
      if (kept_dist[i] > kept_dist[best]) best = i;
    return best;
  endfunction

  task automatic predict_item(input op_t op, input logic [31:0] x, input logic [31:0] y);
    int k;
    int m;
    logic [DIST_W-1:0] d;
    kth_result_t r;
    k = int'(keep_reg);
    if (k == 0) k = 1;
    if (k > MAX_KEEP) k = MAX_KEEP;
    if (op == OP_INSERT) begin
      d = square_distance(x, y);
      if (held_num < k) begin
        kept_dist[held_num] = d;
        held_num++;
      end else if (held_num > 0) begin
        m = largest_slot();
        if (d < kept_dist[m]) kept_dist[m] = d;
      end
    end else begin
      if (held_num == 0) begin
        r.kth_dist = '0;
        r.empty = 1'b1;
      end else begin
        r.kth_dist = kept_dist[largest_slot()];
        r.empty = 1'b0;
      end
      pending_kth.push_back(r);
    end
  endtask

  // Called at a falling edge; returns at a falling edge.
  task automatic send_item(input op_t op, input logic [31:0] x, input logic [31:0] y);
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = {y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_item(op, x, y);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        in_tvalid = 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
  endtask

  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (pending_kth.size() != 0) @(negedge clk);
    // inserts behind the last query may still be in the pipeline
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_keep(input logic [CNT_W-1:0] value);
    wait_idle();
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    keep_reg = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [31:0] random_coord();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2, 3: return 32'($signed($urandom_range(0, 16)) - 8);
      4: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return 32'($signed($urandom_range(0, 65535)) - 32768);
    endcase
  endfunction

  task automatic test_empty_and_extremes();
    send_item(OP_QUERY, 32'd0, 32'd0);
    send_item(OP_INSERT, 32'h8000_0000, 32'h8000_0000);
    send_item(OP_QUERY, 32'hffff_ffff, 32'hffff_ffff);
    send_item(OP_INSERT, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(OP_QUERY, 32'd0, 32'd0);
    send_item(OP_INSERT, 32'd0, 32'd0);
    send_item(OP_QUERY, 32'd0, 32'd0);
  endtask

  task automatic test_equal_and_shrink();
    write_keep(CNT_W'(4));
    send_item(OP_INSERT, 32'd3, 32'hffff_fffc);
    send_item(OP_INSERT, 32'hffff_fffb, 32'd0);
    send_item(OP_INSERT, 32'd100, 32'd7);
    send_item(OP_QUERY, 32'd0, 32'd0);
    // equal to the largest held value, but fewer than four are held: it is added
    send_item(OP_INSERT, 32'd7, 32'hffff_ff9c);
    send_item(OP_QUERY, 32'd0, 32'd0);
    // keep count below held count: nothing is dropped
    write_keep(CNT_W'(2));
    send_item(OP_INSERT, 32'd1, 32'd1);
    send_item(OP_QUERY, 32'd0, 32'd0);
    send_item(OP_INSERT, 32'd2, 32'd2);
    send_item(OP_QUERY, 32'd0, 32'd0);
  endtask

  task automatic run_random_phase(input logic [CNT_W-1:0] keep, input int count,
                                  input int query_odds);
    op_t op;
    write_keep(keep);
    for (int i = 0; i < count; i++) begin
      // alternate stretches with and without sender gaps
      if (i % 40 == 0) gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
      op = ($urandom_range(1, query_odds) == 1) ? OP_QUERY : OP_INSERT;
      send_item(op, random_coord(), random_coord());
    end
  endtask

  task automatic test_random_keep_counts();
    run_random_phase(CNT_W'(3), 80, 4);
    run_random_phase(CNT_W'(0), 60, 4);
    run_random_phase(CNT_W'(64), 150, 6);
    run_random_phase(CNT_W'(127), 130, 6);
    run_random_phase(CNT_W'(1), 60, 4);
    run_random_phase(CNT_W'($urandom_range(0, 127)), 100, 4);
    run_random_phase(CNT_W'($urandom_range(0, 127)), 100, 4);
  endtask

  task automatic test_backpressure();
    op_t op;
    write_keep(CNT_W'(16));
    gap_max = 0;
    hold_reqs++;
    for (int i = 0; i < 40; i++) begin
      op = (i % 2 == 1) ? OP_QUERY : OP_INSERT;
      send_item(op, random_coord(), random_coord());
    end
    gap_max = 4;
  endtask

  // Receiver: own stall pattern plus requested long holds.
  always @(negedge clk) begin
    if (hold_served != hold_reqs) begin
      hold_served <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      rx_count <= rx_count + 1;
      if (rx_count % 64 == 0) rx_mode <= $urandom_range(0, 2);
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        default: out_tready <= (rx_count % 7) < 4;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_kth.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: dist %h empty %b", out_tdata, out_tuser);
      end else begin
        front_kth = pending_kth.pop_front();
        if (out_tdata !== front_kth.kth_dist || out_tuser !== front_kth.empty) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: dist exp %h got %h, empty exp %b got %b",
                     front_kth.kth_dist, out_tdata, front_kth.empty, out_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_empty_and_extremes();
    test_equal_and_shrink();
    test_backpressure();
    test_random_keep_counts();
    wait_idle();
    if (mismatch_count == 0 && pending_kth.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/kssd_pkg.sv
hw/rtl/kssd_dist.sv
hw/rtl/kssd_cell.sv
hw/rtl/kth_smallest_squared_distance.sv
tb/kth_smallest_squared_distance_tb.sv
